// ===== rtl/mkit_pkg.sv =====
// mkit_pkg: request/response payload types, request and status codes,
// and register indexes of the keyframe index table. No dependencies.
package mkit_pkg;

   localparam int DATA_W    = 32;
   localparam int DIV_STEPS = 32;
   localparam logic [DATA_W-1:0] NONE_POS = '1;

   localparam logic [2:0] REQ_ADD     = 3'd0;
   localparam logic [2:0] REQ_IS_KEY  = 3'd1;
   localparam logic [2:0] REQ_NEXT    = 3'd2;
   localparam logic [2:0] REQ_PREV    = 3'd3;
   localparam logic [2:0] REQ_NEAREST = 3'd4;
   localparam logic [2:0] REQ_FIND    = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [2:0] CSR_START_POS     = 3'd0;
   localparam logic [2:0] CSR_SAMPLE_SIZE   = 3'd1;
   localparam logic [2:0] CSR_IS_AUDIO      = 3'd2;
   localparam logic [2:0] CSR_VBR_SCALE     = 3'd3;
   localparam logic [2:0] CSR_STREAM_LENGTH = 3'd4;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [DATA_W-1:0] chunk_offset;
      logic [DATA_W-1:0] chunk_len;
      logic              chunk_is_key;
      logic [DATA_W-1:0] query_pos;
   } mkit_req_type;

   typedef struct packed {
      logic [14:0]       key_count;
      logic [DATA_W-1:0] key_bytes;
      logic [DATA_W-1:0] key_max;
      logic [DATA_W-1:0] key_min;
      logic [DATA_W-1:0] delta_bytes;
      logic [DATA_W-1:0] delta_max;
      logic [DATA_W-1:0] delta_min;
      logic [DATA_W-1:0] total_bytes;
   } mkit_stats_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] result_pos;
      logic              key_flag;
      logic [14:0]       key_count;
      logic [DATA_W-1:0] key_bytes;
      logic [DATA_W-1:0] key_max;
      logic [DATA_W-1:0] key_min;
      logic [DATA_W-1:0] delta_bytes;
      logic [DATA_W-1:0] delta_max;
      logic [DATA_W-1:0] delta_min;
      logic [DATA_W-1:0] total_bytes;
      logic [14:0]       entry_count;
   } mkit_rsp_type;

endpackage

// ===== rtl/mkit_if.sv =====
// mkit_req_if / mkit_rsp_if: valid/ready channels of the index table.
// Depends on mkit_pkg for the payload types.
interface mkit_req_if import mkit_pkg::*; ();
   logic         valid;
   logic         ready;
   mkit_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mkit_rsp_if import mkit_pkg::*; ();
   logic         valid;
   logic         ready;
   mkit_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mkit_div.sv =====
// mkit_div: restoring divider, one quotient bit per cycle, gives the
// ceiling of dividend / divisor. Depends on mkit_pkg.
module mkit_div import mkit_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIV_STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], ~diff[DATA_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   // round up when anything is left over
   assign done     = done_ff;
   assign quotient = quo_ff + DATA_W'(rem_ff != '0);
endmodule

// ===== rtl/mkit_stats.sv =====
// mkit_stats: running key/delta chunk size totals, maxima and minima.
// Depends on mkit_pkg for the statistics struct.
module mkit_stats import mkit_pkg::*; #(
   parameter int CNT_W = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              update,
   input  logic [DATA_W-1:0] len,
   input  logic              is_key,
   output mkit_stats_type    stats
);
   logic [CNT_W-1:0]  key_cnt_ff, key_cnt_in;
   logic [DATA_W-1:0] key_tot_ff, key_tot_in;
   logic [DATA_W-1:0] key_max_ff, key_max_in;
   logic [DATA_W-1:0] key_min_ff, key_min_in;
   logic [DATA_W-1:0] dlt_tot_ff, dlt_tot_in;
   logic [DATA_W-1:0] dlt_max_ff, dlt_max_in;
   logic [DATA_W-1:0] dlt_min_ff, dlt_min_in;
   logic [DATA_W-1:0] all_tot_ff, all_tot_in;

   always_comb begin
      key_cnt_in = key_cnt_ff;
      key_tot_in = key_tot_ff;
      key_max_in = key_max_ff;
      key_min_in = key_min_ff;
      dlt_tot_in = dlt_tot_ff;
      dlt_max_in = dlt_max_ff;
      dlt_min_in = dlt_min_ff;
      all_tot_in = all_tot_ff;
      if (update) begin
         all_tot_in = all_tot_ff + len;
         if (is_key) begin
            key_cnt_in = key_cnt_ff + 1'b1;
            key_tot_in = key_tot_ff + len;
            if (key_max_ff < len) key_max_in = len;
            if (key_min_ff > len) key_min_in = len;
         end else begin
            dlt_tot_in = dlt_tot_ff + len;
            if (dlt_max_ff < len) dlt_max_in = len;
            if (dlt_min_ff > len) dlt_min_in = len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_cnt_ff <= '0;
         key_tot_ff <= '0;
         key_max_ff <= '0;
         key_min_ff <= '1;
         dlt_tot_ff <= '0;
         dlt_max_ff <= '0;
         dlt_min_ff <= '1;
         all_tot_ff <= '0;
      end else begin
         key_cnt_ff <= key_cnt_in;
         key_tot_ff <= key_tot_in;
         key_max_ff <= key_max_in;
         key_min_ff <= key_min_in;
         dlt_tot_ff <= dlt_tot_in;
         dlt_max_ff <= dlt_max_in;
         dlt_min_ff <= dlt_min_in;
         all_tot_ff <= all_tot_in;
      end
   end

   assign stats.key_count   = 15'(key_cnt_ff);
   assign stats.key_bytes   = key_tot_ff;
   assign stats.key_max     = key_max_ff;
   assign stats.key_min     = key_min_ff;
   assign stats.delta_bytes = dlt_tot_ff;
   assign stats.delta_max   = dlt_max_ff;
   assign stats.delta_min   = dlt_min_ff;
   assign stats.total_bytes = all_tot_ff;
endmodule

// ===== rtl/media_keyframe_index_table.sv =====
// media_keyframe_index_table: chunk index of one stream with keyframe searches.
// Depends on mkit_pkg, mkit_if, mkit_div and mkit_stats.
//
// Requests come in on req_ch (valid/ready), one response per request leaves on
// rsp_ch. Every response carries the statistics as they stand after the request.
// The block works on one request at a time; a new request is taken once the
// previous one has been placed in the response register, so one response may
// wait for the receiver while the next request is already in work.
// An add for VBR audio waits for the 32-step divider. Next/prev key scan the
// index with one memory read per entry scanned, nearest may run both scans,
// and find runs a binary search over the position memory.
// The mark and position memories have one read port each, read data registered.
// Reset clears counters and statistics; the memories are not cleared, entries
// past the fill counts are never read. A stalled receiver holds the finished
// response and the block then waits before taking its next result.
// Registers are written through csr_we/csr_index/csr_wdata; the user must write
// them only while idle, as the block itself does not enforce it.
module media_keyframe_index_table import mkit_pkg::*; #(
   parameter int MAX_ENTRIES = 16384
) (
   input  logic              clock,
   input  logic              reset,
   mkit_req_if.sink          req_ch,
   mkit_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [DATA_W-1:0] csr_wdata
);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_ADD_DIV = 5'd1;
   localparam logic [4:0] S_ADD_WR  = 5'd2;
   localparam logic [4:0] S_KEY_CK  = 5'd3;
   localparam logic [4:0] S_PV_GO   = 5'd4;
   localparam logic [4:0] S_PV_RD   = 5'd5;
   localparam logic [4:0] S_PV_CK   = 5'd6;
   localparam logic [4:0] S_NX_GO   = 5'd7;
   localparam logic [4:0] S_NX_RD   = 5'd8;
   localparam logic [4:0] S_NX_CK   = 5'd9;
   localparam logic [4:0] S_F_MUL   = 5'd10;
   localparam logic [4:0] S_F_SET   = 5'd11;
   localparam logic [4:0] S_F_CMP   = 5'd12;
   localparam logic [4:0] S_BS_RD   = 5'd13;
   localparam logic [4:0] S_BS_CK   = 5'd14;
   localparam logic [4:0] S_BS_CK2  = 5'd15;
   localparam logic [4:0] S_FIN     = 5'd16;

   // configuration
   logic [DATA_W-1:0] start_pos_ff, vbr_scale_ff, stream_len_ff;
   logic [15:0]       sample_size_ff;
   logic              is_audio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff   <= '0;
         sample_size_ff <= '0;
         is_audio_ff    <= 1'b0;
         vbr_scale_ff   <= '0;
         stream_len_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_POS:     start_pos_ff   <= csr_wdata;
            CSR_SAMPLE_SIZE:   sample_size_ff <= csr_wdata[15:0];
            CSR_IS_AUDIO:      is_audio_ff    <= csr_wdata[0];
            CSR_VBR_SCALE:     vbr_scale_ff   <= csr_wdata;
            CSR_STREAM_LENGTH: stream_len_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic ss_on, vbr_on;
   assign ss_on  = sample_size_ff != '0;
   assign vbr_on = is_audio_ff && (vbr_scale_ff != '0);

   // control and working registers
   logic [4:0]        state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic [DATA_W-1:0] len_ff, len_in;
   logic              key_ff, key_in;
   logic              mark_ff, mark_in;
   logic [DATA_W-1:0] idx_ff, idx_in;
   logic [DATA_W-1:0] pv_ff, pv_in;
   logic [DATA_W-1:0] tgt_ff, tgt_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              flag_ff, flag_in;
   logic [1:0]        status_ff, status_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [AW-1:0]     mid_ff, mid_in;
   logic [CW-1:0]     ec_ff, ec_in;
   logic [CW-1:0]     pc_ff, pc_in;
   logic [DATA_W-1:0] last_pos_ff, last_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mkit_rsp_type      rsp_data_ff, rsp_data_in;

   // memories
   logic              mark_mem [MAX_ENTRIES];
   logic [DATA_W-1:0] pos_mem [MAX_ENTRIES];
   logic              mark_rd_ff;
   logic [DATA_W-1:0] pos_rd_ff;
   logic              mark_we, mark_re, pos_we, pos_re;
   logic [AW-1:0]     mark_wa, mark_ra, pos_wa, pos_ra;
   logic [DATA_W-1:0] pos_wd;

   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_wa] <= mark_ff;
      if (mark_re) mark_rd_ff <= mark_mem[mark_ra];
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_wa] <= pos_wd;
      if (pos_re) pos_rd_ff <= pos_mem[pos_ra];
   end

   // divider and statistics
   logic              div_start, div_done;
   logic [DATA_W-1:0] div_quo;
   logic              stat_upd;
   mkit_stats_type    stats;

   mkit_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_ch.data.chunk_len),
      .divisor  (vbr_scale_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   mkit_stats #(.CNT_W(CW)) u_stats (
      .clock  (clock),
      .reset  (reset),
      .update (stat_upd),
      .len    (len_ff),
      .is_key (key_ff),
      .stats  (stats)
   );

   logic              req_fire;
   logic [DATA_W-1:0] req_idx, ec32, idx_dec, idx_inc, prod_len;
   logic [47:0]       prod;
   logic [AW:0]       mid_sum;
   logic [CW-1:0]     pc_dec;
   logic [DATA_W-1:0] find_pos, pv_val, nx_val;
   logic              pv_done, nx_done, rsp_load;

   assign req_ch.ready = state_ff == S_IDLE;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_idx      = req_ch.data.query_pos - start_pos_ff;
   assign ec32         = DATA_W'(ec_ff);
   assign idx_dec      = idx_ff - 1'b1;
   assign idx_inc      = idx_ff + 1'b1;
   assign prod         = stream_len_ff * sample_size_ff;
   assign prod_len     = ss_on ? prod[DATA_W-1:0] : stream_len_ff;
   assign mid_sum      = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
   assign pc_dec       = pc_ff - 1'b1;
   assign find_pos     = (q_ff >= tgt_ff || q_ff == NONE_POS) ? tgt_ff : q_ff;
   assign rsp_load     = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      q_in        = q_ff;
      len_in      = len_ff;
      key_in      = key_ff;
      mark_in     = mark_ff;
      idx_in      = idx_ff;
      pv_in       = pv_ff;
      tgt_in      = tgt_ff;
      res_in      = res_ff;
      flag_in     = flag_ff;
      status_in   = status_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      ec_in       = ec_ff;
      pc_in       = pc_ff;
      last_pos_in = last_pos_ff;
      mark_we     = 1'b0;
      mark_re     = 1'b0;
      mark_wa     = ec_ff[AW-1:0];
      mark_ra     = idx_ff[AW-1:0];
      pos_we      = 1'b0;
      pos_re      = 1'b0;
      pos_wa      = pc_ff[AW-1:0];
      pos_ra      = mid_sum[AW-1:0];
      pos_wd      = stats.total_bytes;
      div_start   = 1'b0;
      stat_upd    = 1'b0;
      pv_done     = 1'b0;
      nx_done     = 1'b0;
      pv_val      = NONE_POS;
      nx_val      = NONE_POS;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_ch.data.req_type;
               q_in      = req_ch.data.query_pos;
               len_in    = req_ch.data.chunk_len;
               key_in    = req_ch.data.chunk_is_key;
               mark_in   = req_ch.data.chunk_is_key | req_ch.data.chunk_offset[0];
               idx_in    = req_idx;
               res_in    = '0;
               flag_in   = 1'b0;
               status_in = ST_OK;
               state_in  = S_FIN;
               case (req_ch.data.req_type)
                  REQ_ADD: begin
                     if (ec_ff == CW'(MAX_ENTRIES)) begin
                        status_in = ST_FULL;
                     end else if (!ss_on && vbr_on) begin
                        div_start = 1'b1;
                        state_in  = S_ADD_DIV;
                     end else begin
                        state_in = S_ADD_WR;
                     end
                  end
                  REQ_IS_KEY: begin
                     if (ss_on || req_idx >= ec32) begin
                        flag_in = 1'b1;
                     end else begin
                        mark_re  = 1'b1;
                        mark_ra  = req_idx[AW-1:0];
                        state_in = S_KEY_CK;
                     end
                  end
                  REQ_NEXT: state_in = S_NX_GO;
                  REQ_PREV: state_in = S_PV_GO;
                  REQ_NEAREST: begin
                     if (req_idx < ec32 && req_idx != NONE_POS) begin
                        mark_re  = 1'b1;
                        mark_ra  = req_idx[AW-1:0];
                        state_in = S_KEY_CK;
                     end
                  end
                  REQ_FIND: state_in = S_F_MUL;
                  default: res_in = NONE_POS;
               endcase
            end
         end
         S_ADD_DIV: begin
            if (div_done) state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            mark_we  = 1'b1;
            stat_upd = 1'b1;
            ec_in    = ec_ff + 1'b1;
            if (ss_on || vbr_on) begin
               pos_we      = 1'b1;
               pos_wd      = ss_on ? stats.total_bytes : last_pos_ff + div_quo;
               pc_in       = pc_ff + 1'b1;
               last_pos_in = pos_wd;
            end
            state_in = S_FIN;
         end
         S_KEY_CK: begin
            if (op_ff == REQ_IS_KEY) begin
               flag_in  = mark_rd_ff;
               state_in = S_FIN;
            end else if (mark_rd_ff) begin
               res_in   = q_ff;
               state_in = S_FIN;
            end else begin
               state_in = S_PV_GO;
            end
         end
         S_PV_GO: begin
            if (ss_on) begin
               pv_done = 1'b1;
               pv_val  = q_ff;
            end else if (idx_ff > ec32 || idx_ff == NONE_POS) begin
               pv_done = 1'b1;
            end else if (idx_ff <= DATA_W'(1)) begin
               // small index answers one, start not added
               pv_done = 1'b1;
               pv_val  = DATA_W'(1);
            end else begin
               idx_in   = idx_dec;
               state_in = S_PV_RD;
            end
         end
         S_PV_RD: begin
            if (idx_ff == '0) begin
               pv_done = 1'b1;
               pv_val  = start_pos_ff;
            end else begin
               mark_re  = 1'b1;
               mark_ra  = idx_dec[AW-1:0];
               idx_in   = idx_dec;
               state_in = S_PV_CK;
            end
         end
         S_PV_CK: begin
            if (mark_rd_ff) begin
               pv_done = 1'b1;
               pv_val  = idx_ff + start_pos_ff;
            end else begin
               state_in = S_PV_RD;
            end
         end
         S_NX_GO: begin
            if (ss_on) begin
               nx_done = 1'b1;
               nx_val  = q_ff;
            end else begin
               state_in = S_NX_RD;
            end
         end
         S_NX_RD: begin
            if (idx_ff < ec32) begin
               mark_re  = 1'b1;
               state_in = S_NX_CK;
            end else begin
               nx_done = 1'b1;
            end
         end
         S_NX_CK: begin
            if (mark_rd_ff) begin
               nx_done = 1'b1;
               nx_val  = idx_ff + start_pos_ff;
            end else begin
               idx_in   = idx_inc;
               state_in = S_NX_RD;
            end
         end
         S_F_MUL: begin
            tgt_in   = prod_len;
            state_in = S_F_SET;
         end
         S_F_SET: begin
            tgt_in   = tgt_ff + start_pos_ff;
            state_in = S_F_CMP;
         end
         S_F_CMP: begin
            tgt_in   = find_pos - start_pos_ff;
            state_in = S_FIN;
            if (q_ff <= start_pos_ff) begin
               res_in = '0;
            end else if (pc_ff == '0) begin
               res_in = ss_on ? '0 : tgt_in;
            end else begin
               lo_in    = '0;
               hi_in    = pc_dec[AW-1:0];
               state_in = S_BS_RD;
            end
         end
         S_BS_RD: begin
            if (lo_ff == hi_ff) begin
               res_in   = DATA_W'(lo_ff);
               state_in = S_FIN;
            end else begin
               pos_re   = 1'b1;
               mid_in   = mid_sum[AW-1:0];
               state_in = S_BS_CK;
            end
         end
         S_BS_CK: begin
            if (tgt_ff >= pos_rd_ff) begin
               if (mid_ff == lo_ff) begin
                  res_in   = DATA_W'(lo_ff);
                  state_in = S_FIN;
               end else begin
                  lo_in    = mid_ff;
                  pos_re   = 1'b1;
                  pos_ra   = mid_ff + 1'b1;
                  state_in = S_BS_CK2;
               end
            end else begin
               hi_in    = mid_ff;
               state_in = S_BS_RD;
            end
         end
         S_BS_CK2: begin
            if (tgt_ff < pos_rd_ff) begin
               res_in   = DATA_W'(lo_ff);
               state_in = S_FIN;
            end else begin
               state_in = S_BS_RD;
            end
         end
         S_FIN: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // end of a previous-key scan: answer, or go on to the next-key scan
      if (pv_done) begin
         if (op_ff == REQ_PREV) begin
            res_in   = pv_val;
            state_in = S_FIN;
         end else begin
            pv_in    = pv_val;
            idx_in   = q_ff - start_pos_ff;
            state_in = S_NX_GO;
         end
      end
      if (nx_done) begin
         if (op_ff == REQ_NEXT) begin
            res_in = nx_val;
         end else begin
            res_in = ((q_ff - pv_ff) < (nx_val - q_ff)) ? pv_ff : nx_val;
         end
         state_in = S_FIN;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = (op_ff >= REQ_NEXT && res_ff == NONE_POS) ?
                                   ST_NONE : status_ff;
         rsp_data_in.result_pos  = res_ff;
         rsp_data_in.key_flag    = flag_ff;
         rsp_data_in.key_count   = stats.key_count;
         rsp_data_in.key_bytes   = stats.key_bytes;
         rsp_data_in.key_max     = stats.key_max;
         rsp_data_in.key_min     = stats.key_min;
         rsp_data_in.delta_bytes = stats.delta_bytes;
         rsp_data_in.delta_max   = stats.delta_max;
         rsp_data_in.delta_min   = stats.delta_min;
         rsp_data_in.total_bytes = stats.total_bytes;
         rsp_data_in.entry_count = 15'(ec_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ec_ff        <= '0;
         pc_ff        <= '0;
         last_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ec_ff        <= ec_in;
         pc_ff        <= pc_in;
         last_pos_ff  <= last_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      q_ff        <= q_in;
      len_ff      <= len_in;
      key_ff      <= key_in;
      mark_ff     <= mark_in;
      idx_ff      <= idx_in;
      pv_ff       <= pv_in;
      tgt_ff      <= tgt_in;
      res_ff      <= res_in;
      flag_ff     <= flag_in;
      status_ff   <= status_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   a_ec_bound: assert property (@(posedge clock) disable iff (reset)
      ec_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= ec_ff)
      else $error("position count ahead of entry count");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_ADD_DIV)
      else $error("divider finished outside an add");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished request did not reach the response register");
endmodule
